FILE: hdl/hpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpf_pkg
// Types, register map and defaults shared by the heatmap peak finder.
// ----------------------------------------------------------------------------
package hpf_pkg;

  localparam int DEF_MAX_WIDTH    = 256;
  localparam int DEF_MAX_HEIGHT   = 256;
  localparam int DEF_MAX_CHANNELS = 64;

  localparam logic [8:0]  RST_FRAME_WIDTH  = 9'd256;
  localparam logic [8:0]  RST_FRAME_HEIGHT = 9'd256;
  localparam logic [15:0] RST_THRESHOLD    = 16'd410;
  localparam logic [6:0]  RST_CHANNELS     = 7'd18;

  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESHOLD    = 2'd2;
  localparam logic [1:0] REG_CHANNELS     = 2'd3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [15:0] PEAK_NUMBER_MAX = 16'hFFFF;

  typedef struct packed {
    logic               op;
    logic signed [15:0] heat;
  } pixel_t;

  typedef struct packed {
    logic [7:0]         peak_x;
    logic [7:0]         peak_y;
    logic [5:0]         peak_channel;
    logic signed [15:0] peak_score;
    logic [15:0]        peak_number;
  } peak_t;

endpackage

FILE: hdl/hpf_line_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpf_line_buffer
// One row of heat values: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module hpf_line_buffer #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_right,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [15:0]              wr_data,
  output logic [15:0]              rd_data,
  output logic [15:0]              rd_data_right
);

  logic [15:0] mem [DEPTH];

  // read returns the old entry when the same address is written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data       <= mem[rd_addr];
      rd_data_right <= mem[rd_addr_right];
    end
  end

endmodule

FILE: hdl/heatmap_peak_finder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heatmap_peak_finder_top
// Streaming four-neighbour local-maximum peak detector for heatmaps.
// ----------------------------------------------------------------------------
// Takes one pixel or drain beat per clock while stall is low. Pixel (x, y)
// is decided on the beat at (x, y+1), or on the drain beat at column x for
// the last row; its peak is found in stage 1, then queued for output.
// Two line buffers, each with two read ports, supply center, right and up
// in one access, so the rate stays one beat per cycle while stall is low;
// the four-entry output queue raises stall only while peaks back up behind
// a stalled output. Line buffers need no clearing after reset.
module heatmap_peak_finder_top
  import hpf_pkg::*;
#(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  pixel_t            pixel,
  output logic              peak_valid,
  input  logic              peak_stall,
  output peak_t             peak,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CHW = $clog2(MAX_CHANNELS + 1);

  // configuration registers
  logic [8:0]  frame_width;
  logic [8:0]  frame_height;
  logic [15:0] peak_threshold;
  logic [6:0]  channels_per_frame;

  logic cfg_write;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width        <= RST_FRAME_WIDTH;
      frame_height       <= RST_FRAME_HEIGHT;
      peak_threshold     <= RST_THRESHOLD;
      channels_per_frame <= RST_CHANNELS;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_FRAME_WIDTH:  frame_width        <= pwdata[8:0];
        REG_FRAME_HEIGHT: frame_height       <= pwdata[8:0];
        REG_THRESHOLD:    peak_threshold     <= pwdata[15:0];
        REG_CHANNELS:     channels_per_frame <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      REG_THRESHOLD:    prdata = 32'(peak_threshold);
      REG_CHANNELS:     prdata = 32'(channels_per_frame);
      default:          prdata = '0;
    endcase
  end

  // clamped geometry
  logic [WW-1:0]  w;
  logic [HW-1:0]  h;
  logic [CHW-1:0] ch;

  always_comb begin
    if (frame_width == '0) begin
      w = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h = HW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(frame_height);
    end
    if (channels_per_frame == '0) begin
      ch = CHW'(1);
    end else if (32'(channels_per_frame) > MAX_CHANNELS) begin
      ch = CHW'(MAX_CHANNELS);
    end else begin
      ch = CHW'(channels_per_frame);
    end
  end

  // stage 0: position counters, line buffer access
  logic [AW-1:0] column_count;
  logic [HW-1:0] row_count;
  logic [CW-1:0] channel_count;
  logic          row_select;

  logic               accept;
  logic               drain_row;
  logic               row_end;
  logic               frame_end;
  logic signed [15:0] heat_in;
  logic [AW-1:0]      x_right;

  assign accept    = pixel_valid && !pixel_stall;
  assign drain_row = 32'(row_count) >= 32'(h);
  assign row_end   = (32'(column_count) + 1) >= 32'(w);
  assign frame_end = row_end && drain_row && ((32'(channel_count) + 1) >= 32'(ch));
  assign heat_in   = (pixel.op == OP_PIXEL) ? pixel.heat : 16'sd0;
  assign x_right   = column_count + AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      channel_count <= '0;
      row_select    <= 1'b0;
    end else if (accept) begin
      if (row_end) begin
        column_count <= '0;
        row_select   <= ~row_select;
        if (drain_row) begin
          row_count <= '0;
          if (frame_end) begin
            channel_count <= '0;
          end else begin
            channel_count <= channel_count + CW'(1);
          end
        end else begin
          row_count <= row_count + HW'(1);
        end
      end else begin
        column_count <= column_count + AW'(1);
      end
    end
  end

  logic [15:0] buf0_data, buf0_right, buf1_data, buf1_right;

  hpf_line_buffer #(
    .DEPTH(MAX_WIDTH)
  ) u_buf0 (
    .clk          (clk),
    .rd_en        (accept),
    .rd_addr      (column_count),
    .rd_addr_right(x_right),
    .wr_en        (accept && !drain_row && !row_select),
    .wr_addr      (column_count),
    .wr_data      (heat_in),
    .rd_data      (buf0_data),
    .rd_data_right(buf0_right)
  );

  hpf_line_buffer #(
    .DEPTH(MAX_WIDTH)
  ) u_buf1 (
    .clk          (clk),
    .rd_en        (accept),
    .rd_addr      (column_count),
    .rd_addr_right(x_right),
    .wr_en        (accept && !drain_row && row_select),
    .wr_addr      (column_count),
    .wr_data      (heat_in),
    .rd_data      (buf1_data),
    .rd_data_right(buf1_right)
  );

  // stage 1: window compare
  logic               s1_valid;
  logic [AW-1:0]      s1_x;
  logic [HW-1:0]      s1_y;
  logic [CW-1:0]      s1_channel;
  logic               s1_eval;
  logic               s1_first_row;
  logic               s1_right_ok;
  logic               s1_sel;
  logic               s1_frame_end;
  logic signed [15:0] s1_down;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x         <= column_count;
      s1_y         <= row_count - HW'(1);
      s1_channel   <= channel_count;
      s1_eval      <= row_count != '0;
      s1_first_row <= row_count == HW'(1);
      s1_right_ok  <= (32'(column_count) + 1) < 32'(w);
      s1_sel       <= row_select;
      s1_frame_end <= frame_end;
      s1_down      <= drain_row ? 16'sd0 : heat_in;
    end
  end

  logic signed [15:0] center, up, left, right, left_hold, thr;
  logic               s1_peak;
  logic [15:0]        peak_count;

  assign thr    = $signed(peak_threshold);
  assign center = s1_sel ? $signed(buf0_data) : $signed(buf1_data);
  assign up     = s1_first_row ? 16'sd0 : (s1_sel ? $signed(buf1_data) : $signed(buf0_data));
  assign right  = !s1_right_ok ? 16'sd0 : (s1_sel ? $signed(buf0_right) : $signed(buf1_right));
  assign left   = (s1_x == '0) ? 16'sd0 : left_hold;

  assign s1_peak = s1_valid && s1_eval && (center > thr) && (center >= up) &&
                   (center >= s1_down) && (center >= left) && (center >= right);

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      left_hold <= center;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_count <= '0;
    end else if (s1_valid) begin
      if (s1_frame_end) begin
        peak_count <= '0;
      end else if (s1_peak && peak_count != PEAK_NUMBER_MAX) begin
        peak_count <= peak_count + 16'd1;
      end
    end
  end

  // output queue
  peak_t               fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr, rd_ptr;
  logic [FIFO_AW:0]    count, count_next;
  logic                push, pop;
  peak_t               new_peak;

  assign push = s1_peak;
  assign pop  = peak_valid && !peak_stall;

  assign new_peak.peak_x       = 8'(s1_x);
  assign new_peak.peak_y       = 8'(s1_y);
  assign new_peak.peak_channel = 6'(s1_channel);
  assign new_peak.peak_score   = center;
  assign new_peak.peak_number  = peak_count;

  assign count_next = count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  assign peak_valid = count != '0;
  assign peak       = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= new_peak;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      count       <= '0;
      pixel_stall <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count       <= count_next;
      // room for the beat in stage 1 and one more
      pixel_stall <= (32'(count_next) + 32'(accept)) >= FIFO_DEPTH;
    end
  end

endmodule

FILE: hdl/hpf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpf_checker
// Port-level checks for the heatmap peak finder, bound to the top level.
// ----------------------------------------------------------------------------
module hpf_checker
  import hpf_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  pixel_stall,
  input logic  peak_valid,
  input logic  peak_stall,
  input peak_t peak,
  input logic  pready
);

  logic [15:0] last_number;
  logic        have_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_last <= 1'b0;
    end else if (peak_valid && !peak_stall) begin
      have_last   <= 1'b1;
      last_number <= peak.peak_number;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !peak_valid && !pixel_stall)
    else $error("queue not empty after reset");

  a_peak_hold: assert property (@(posedge clk) disable iff (rst)
    peak_valid && peak_stall |=> peak_valid && $stable(peak))
    else $error("stalled peak request changed");

  a_numbering: assert property (@(posedge clk) disable iff (rst)
    peak_valid && !peak_stall && have_last |->
      (peak.peak_number == last_number + 16'd1) || (peak.peak_number == 16'd0) ||
      (peak.peak_number == PEAK_NUMBER_MAX && last_number == PEAK_NUMBER_MAX))
    else $error("peak number out of sequence");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind heatmap_peak_finder_top hpf_checker u_hpf_checker (
  .clk        (clk),
  .rst        (rst),
  .pixel_stall(pixel_stall),
  .peak_valid (peak_valid),
  .peak_stall (peak_stall),
  .peak       (peak),
  .pready     (pready)
);
